// ===== rtl/assert_macros.svh =====
// Assertion helpers; clk_i and rst_ni must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define Q8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define Q8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

// ===== rtl/q8d_pkg.sv =====
`default_nettype none
package q8d_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int EW     = 12;
  localparam int RED_LAT = 15;

  typedef logic signed [EW-1:0] exp_t;

  localparam exp_t EXP_ZERO = exp_t'(-1024);
  localparam exp_t F32_ADJ  = exp_t'(150);
  localparam exp_t F32_SUB  = exp_t'(-149);
  localparam exp_t F16_ADJ  = exp_t'(25);
  localparam exp_t F16_SUB  = exp_t'(-24);
  localparam logic [5:0] NORM_TOP = 6'd61;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [31:0] INF  = 32'h7F80_0000;

  typedef enum logic [1:0] {
    CLS_FIN,
    CLS_INF,
    CLS_NAN
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic        sign;
    logic [23:0] mant;
    exp_t        expo;
  } fp_t;

  typedef struct packed {
    logic        special;
    logic [31:0] sval;
    logic        sa;
    logic [47:0] ma;
    exp_t        ea;
    logic        sb;
    logic [23:0] mb;
    exp_t        eb;
  } op_t;

  function automatic fp_t unpack_f32(input logic [31:0] b);
    fp_t r;
    r.sign = b[31];
    r.cls  = CLS_FIN;
    r.mant = {1'b0, b[22:0]};
    r.expo = F32_SUB;
    if (b[30:23] == 8'hFF) begin
      r.cls = (b[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (b[30:23] != 8'd0) begin
      r.mant = {1'b1, b[22:0]};
      r.expo = exp_t'({4'b0, b[30:23]}) - F32_ADJ;
    end
    return r;
  endfunction

  function automatic fp_t unpack_f16(input logic [15:0] b);
    fp_t r;
    r.sign = b[15];
    r.cls  = CLS_FIN;
    r.mant = {14'b0, b[9:0]};
    r.expo = F16_SUB;
    if (b[14:10] == 5'h1F) begin
      r.cls = (b[9:0] != 10'd0) ? CLS_NAN : CLS_INF;
    end else if (b[14:10] != 5'd0) begin
      r.mant = {13'b0, 1'b1, b[9:0]};
      r.expo = exp_t'({7'b0, b[14:10]}) - F16_ADJ;
    end
    return r;
  endfunction

  // a + c with the special operands resolved up front
  function automatic op_t mk_op(input cls_e acls, input logic asign, input logic [47:0] am,
                                input exp_t aexp, input logic [31:0] cb);
    fp_t c;
    op_t o;
    c = unpack_f32(cb);
    o.special = 1'b0;
    o.sval    = '0;
    o.sa      = asign;
    o.ma      = am;
    o.ea      = aexp;
    o.sb      = c.sign;
    o.mb      = c.mant;
    o.eb      = c.expo;
    if (acls == CLS_NAN || c.cls == CLS_NAN) begin
      o.special = 1'b1;
      o.sval    = QNAN;
    end else if (acls == CLS_INF) begin
      o.special = 1'b1;
      o.sval    = (c.cls == CLS_INF && c.sign != asign) ? QNAN : {asign, INF[30:0]};
    end else if (c.cls == CLS_INF) begin
      o.special = 1'b1;
      o.sval    = {c.sign, INF[30:0]};
    end else if (am == 48'd0 && c.mant == 24'd0) begin
      o.special = 1'b1;
      o.sval    = {asign & c.sign, 31'b0};
    end
    return o;
  endfunction

  function automatic op_t mk_add(input logic [31:0] x, input logic [31:0] y);
    fp_t fx;
    fx = unpack_f32(x);
    return mk_op(fx.cls, fx.sign, {24'b0, fx.mant}, fx.expo, y);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/q8d_if.sv =====
`default_nettype none
interface q8d_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] weight;
  logic [15:0]       block_scale;
  logic [31:0]       vector_value;
  logic              last;

  modport source (output valid, weight, block_scale, vector_value, last, input ready);
  modport sink (input valid, weight, block_scale, vector_value, last, output ready);
endinterface

interface q8d_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_result;

  modport source (output valid, dot_result, input ready);
  modport sink (input valid, dot_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/q8d_fadd.sv =====
`default_nettype none
module q8d_fadd import q8d_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire op_t         op_i,
  output logic [31:0]      res_o
);

  typedef struct packed {
    logic        special;
    logic [31:0] sval;
    logic        sa;
    logic [63:0] ma;
    exp_t        ea;
    logic        sb;
    logic [63:0] mb;
    exp_t        eb;
  } nrm_t;

  typedef struct packed {
    logic        special;
    logic [31:0] sval;
    logic        sa;
    logic [63:0] ma;
    logic        sb;
    logic [63:0] mb;
    exp_t        e;
  } aln_t;

  typedef struct packed {
    logic        special;
    logic [31:0] sval;
    logic        sign;
    logic [63:0] m;
    exp_t        e;
  } sum_t;

  typedef struct packed {
    logic              special;
    logic [31:0]       sval;
    logic              sign;
    logic [63:0]       m;
    exp_t              e;
    logic signed [7:0] sh;
  } rnd_t;

  function automatic logic [63:0] stick(input logic [63:0] x, input exp_t d);
    logic [63:0] lost;
    lost = x & ~({64{1'b1}} << d[5:0]);
    if (d >= exp_t'(63)) return {63'b0, |x};
    return (x >> d[5:0]) | {63'b0, |lost};
  endfunction

  nrm_t n_d, n_q;
  aln_t a_d, a_q;
  sum_t s_d, s_q;
  rnd_t r_d, r_q;
  logic [31:0] res_d, res_q;

  // normalize both operands to the same top bit
  logic [5:0] ka, kb;
  always_comb begin
    ka = '0;
    kb = '0;
    for (int i = 0; i < 48; i++) if (op_i.ma[i]) ka = 6'(i);
    for (int i = 0; i < 24; i++) if (op_i.mb[i]) kb = 6'(i);
    n_d.special = op_i.special;
    n_d.sval    = op_i.sval;
    n_d.sa      = op_i.sa;
    n_d.sb      = op_i.sb;
    n_d.ma      = {16'b0, op_i.ma} << (NORM_TOP - ka);
    n_d.mb      = {40'b0, op_i.mb} << (NORM_TOP - kb);
    n_d.ea      = op_i.ea - exp_t'({6'b0, NORM_TOP - ka});
    n_d.eb      = op_i.eb - exp_t'({6'b0, NORM_TOP - kb});
    if (op_i.ma == 48'd0) begin
      n_d.ma = '0;
      n_d.ea = EXP_ZERO;
    end
    if (op_i.mb == 24'd0) begin
      n_d.mb = '0;
      n_d.eb = EXP_ZERO;
    end
  end

  // align the smaller operand, folding lost bits into sticky
  exp_t d;
  always_comb begin
    d = n_q.ea - n_q.eb;
    a_d.special = n_q.special;
    a_d.sval    = n_q.sval;
    a_d.sa      = n_q.sa;
    a_d.sb      = n_q.sb;
    a_d.ma      = n_q.ma;
    a_d.mb      = n_q.mb;
    a_d.e       = n_q.ea;
    if (d >= exp_t'(0)) begin
      a_d.mb = stick(n_q.mb, d);
    end else begin
      a_d.ma = stick(n_q.ma, -d);
      a_d.e  = n_q.eb;
    end
  end

  always_comb begin
    s_d.special = a_q.special;
    s_d.sval    = a_q.sval;
    s_d.e       = a_q.e;
    if (a_q.sa == a_q.sb) begin
      s_d.m    = a_q.ma + a_q.mb;
      s_d.sign = a_q.sa;
    end else if (a_q.ma >= a_q.mb) begin
      s_d.m    = a_q.ma - a_q.mb;
      s_d.sign = a_q.sa;
    end else begin
      s_d.m    = a_q.mb - a_q.ma;
      s_d.sign = a_q.sb;
    end
    if (!a_q.special && s_d.m == 64'd0) begin
      s_d.special = 1'b1;
      s_d.sval    = '0;
    end
  end

  // find the leading one and the right shift, subnormal floor included
  logic [5:0] k;
  exp_t lim, km, shw;
  always_comb begin
    k = '0;
    for (int i = 0; i < 63; i++) if (s_q.m[i]) k = 6'(i);
    lim = F32_SUB - s_q.e;
    km  = exp_t'({6'b0, k}) - exp_t'(23);
    shw = (km > lim) ? km : lim;
    r_d.special = s_q.special;
    r_d.sval    = s_q.sval;
    r_d.sign    = s_q.sign;
    r_d.m       = s_q.m;
    r_d.e       = s_q.e;
    r_d.sh      = 8'(shw);
  end

  logic [24:0] q, q2;
  logic [63:0] rem, half;
  logic        up;
  logic [5:0]  shp;
  logic [4:0]  shn;
  exp_t        t, bt;
  always_comb begin
    rem  = '0;
    half = '0;
    up   = 1'b0;
    shp  = '0;
    shn  = '0;
    if (r_q.sh <= 8'sd0) begin
      shn = 5'(-r_q.sh);
      q   = 25'(r_q.m << shn);
    end else begin
      shp  = r_q.sh[5:0];
      q    = 25'(r_q.m >> shp);
      rem  = r_q.m & ~({64{1'b1}} << shp);
      half = 64'd1 << (shp - 6'd1);
      up   = (rem > half) || (rem == half && q[0]);
    end
    q2 = q + 25'(up);
    t  = r_q.e + exp_t'(r_q.sh);
    if (q2[24]) begin
      q2 = q2 >> 1;
      t  = t + exp_t'(1);
    end
    bt = t + F32_ADJ;
    if (q2[23]) begin
      if (bt >= exp_t'(255)) res_d = {r_q.sign, INF[30:0]};
      else res_d = {r_q.sign, bt[7:0], q2[22:0]};
    end else begin
      res_d = {r_q.sign, 8'b0, q2[22:0]};
    end
    if (r_q.special) res_d = r_q.sval;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      a_q   <= a_d;
      s_q   <= s_d;
      r_q   <= r_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/quantized_q8_block_dot.sv =====
`default_nettype none
// Q8 block dot product: one element (int8 weight, binary16 block scale, binary32
// vector value) per beat at one beat per clock while input is not stalled. Each
// element is fused into one of eight binary32 lane accumulators, lane = element
// count mod 8, with a single rounding. A beat marked last also triggers the fixed
// pairwise reduction of the eight lanes, which runs through a registered
// three-level adder tree; the lanes and lane count start over for the next beat.
// Arithmetic is IEEE binary32, round to nearest even, subnormals kept, NaNs given
// as 0x7FC00000. Input is stalled only while a finished result waits unread and
// another one is ready to leave the tree.
`include "assert_macros.svh"
module quantized_q8_block_dot import q8d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  q8d_in_if.sink    in_i,
  q8d_out_if.source out_o
);

  localparam int FS = 8;

  logic en, in_fire, pend_last;
  logic [FS-1:0] fv_q, fl_q;
  logic [FS-1:0][LANE_W-1:0] fi_q;
  logic [LANE_W-1:0] lane_cnt_q;
  logic [LANES-1:0][31:0] lanes_q, snap_q, snap_d;
  logic [RED_LAT:0] rv_q;
  logic out_v_q;
  logic [31:0] out_d_q;

  assign en        = !(out_v_q && !out_o.ready && rv_q[RED_LAT]);
  assign in_i.ready = en;
  assign in_fire   = in_i.valid && en;

  // stage 1: beat capture
  logic signed [7:0] w_q;
  logic [15:0] bs_q;
  logic [31:0] v1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q  <= in_i.weight;
      bs_q <= in_i.block_scale;
      v1_q <= in_i.vector_value;
    end
  end

  // stage 2: weight times scale, exact
  fp_t s16;
  logic [7:0] wmag;
  cls_e p_cls_d, p_cls_q;
  logic [18:0] p_mant_d, p_mant_q;
  logic p_sign_q;
  exp_t p_exp_q;
  logic [31:0] v2_q;
  always_comb begin
    s16      = unpack_f16(bs_q);
    wmag     = w_q[7] ? (~w_q + 8'd1) : w_q;
    p_mant_d = wmag * s16.mant[10:0];
    if (s16.cls == CLS_NAN || (s16.cls == CLS_INF && wmag == 8'd0)) p_cls_d = CLS_NAN;
    else p_cls_d = s16.cls;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cls_q  <= p_cls_d;
      p_sign_q <= w_q[7] ^ s16.sign;
      p_mant_q <= p_mant_d;
      p_exp_q  <= s16.expo;
      v2_q     <= v1_q;
    end
  end

  // stage 3: product with the vector value, lane read
  fp_t v;
  logic [42:0] prod_m;
  logic pz, vz;
  cls_e pv_cls;
  logic [31:0] lane_rd;
  op_t op_d, op_q;
  assign pend_last = |(fv_q[FS-1:2] & fl_q[FS-1:2]);
  always_comb begin
    v       = unpack_f32(v2_q);
    prod_m  = p_mant_q * v.mant;
    pz      = (p_cls_q == CLS_FIN) && (p_mant_q == 19'd0);
    vz      = (v.cls == CLS_FIN) && (v.mant == 24'd0);
    if (p_cls_q == CLS_NAN || v.cls == CLS_NAN || (p_cls_q == CLS_INF && vz) ||
        (v.cls == CLS_INF && pz)) pv_cls = CLS_NAN;
    else if (p_cls_q == CLS_INF || v.cls == CLS_INF) pv_cls = CLS_INF;
    else pv_cls = CLS_FIN;
    // a last beat still in flight clears the lanes before this one lands
    lane_rd = pend_last ? 32'd0 : lanes_q[fi_q[1]];
    op_d    = mk_op(pv_cls, p_sign_q ^ v.sign, {5'b0, prod_m}, p_exp_q + v.expo, lane_rd);
  end

  always_ff @(posedge clk_i) begin
    if (en) op_q <= op_d;
  end

  logic [31:0] acc_res;
  q8d_fadd u_acc (
    .clk_i (clk_i),
    .en_i  (en),
    .op_i  (op_q),
    .res_o (acc_res)
  );

  always_comb begin
    snap_d = lanes_q;
    snap_d[fi_q[FS-1]] = acc_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q       <= '0;
      fl_q       <= '0;
      fi_q       <= '0;
      lane_cnt_q <= '0;
      lanes_q    <= '0;
      rv_q       <= '0;
    end else if (en) begin
      fv_q <= {fv_q[FS-2:0], in_i.valid};
      fl_q <= {fl_q[FS-2:0], in_i.last};
      fi_q <= {fi_q[FS-2:0], lane_cnt_q};
      rv_q <= {rv_q[RED_LAT-1:0], fv_q[FS-1] & fl_q[FS-1]};
      if (in_i.valid) lane_cnt_q <= in_i.last ? '0 : LANE_W'(lane_cnt_q + 1'b1);
      if (fv_q[FS-1]) begin
        if (fl_q[FS-1]) lanes_q <= '0;
        else lanes_q[fi_q[FS-1]] <= acc_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && fv_q[FS-1] && fl_q[FS-1]) snap_q <= snap_d;
  end

  // reduction tree: ((l0+l4)+(l1+l5))+((l2+l6)+(l3+l7))
  op_t [3:0] l1_op;
  op_t [1:0] l2_op;
  op_t l3_op;
  logic [3:0][31:0] l1_res;
  logic [1:0][31:0] l2_res;
  logic [31:0] l3_res;

  always_comb begin
    for (int i = 0; i < 4; i++) l1_op[i] = mk_add(snap_q[i], snap_q[i+4]);
    l2_op[0] = mk_add(l1_res[0], l1_res[1]);
    l2_op[1] = mk_add(l1_res[2], l1_res[3]);
    l3_op    = mk_add(l2_res[0], l2_res[1]);
  end

  for (genvar g = 0; g < 4; g++) begin : g_l1
    q8d_fadd u_add (.clk_i(clk_i), .en_i(en), .op_i(l1_op[g]), .res_o(l1_res[g]));
  end
  for (genvar g = 0; g < 2; g++) begin : g_l2
    q8d_fadd u_add (.clk_i(clk_i), .en_i(en), .op_i(l2_op[g]), .res_o(l2_res[g]));
  end
  q8d_fadd u_l3 (.clk_i(clk_i), .en_i(en), .op_i(l3_op), .res_o(l3_res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en && rv_q[RED_LAT]) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && rv_q[RED_LAT]) out_d_q <= l3_res;
  end

  assign out_o.valid      = out_v_q;
  assign out_o.dot_result = out_d_q;

  `Q8D_ASSERT_NEXT(a_cnt_restart, in_fire && in_i.last, lane_cnt_q == '0, "lane count kept after last beat")
  `Q8D_ASSERT_NEXT(a_lane_clear, en && fv_q[FS-1] && fl_q[FS-1], lanes_q == '0, "lanes not cleared")
  `Q8D_ASSERT_NEXT(a_stall_hold, !en, $stable(fv_q) && $stable(rv_q), "pipeline moved in stall")

endmodule
`default_nettype wire

// ===== tb/sv/q8d_dot_checker.sv =====
`default_nettype none
module q8d_dot_checker import q8d_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  q8d_in_if         in_mon_i,
  q8d_out_if        out_mon_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct {
    cls_e            cls;
    bit              sign;
    longint unsigned mant;
    int              expo;
  } fnum_t;

  bit [31:0] lane_acc [LANES];
  bit [2:0]  lane_ptr;
  bit [31:0] dot_queue [$];

  function automatic fnum_t decode_single(bit [31:0] b);
    fnum_t r;
    r.sign = b[31];
    r.cls  = CLS_FIN;
    r.mant = b[22:0];
    r.expo = -149;
    if (b[30:23] == 8'hFF) begin
      r.cls = (b[22:0] != 0) ? CLS_NAN : CLS_INF;
    end else if (b[30:23] != 0) begin
      r.mant = {1'b1, b[22:0]};
      r.expo = int'(b[30:23]) - 150;
    end
    return r;
  endfunction

  function automatic fnum_t decode_half(bit [15:0] b);
    fnum_t r;
    r.sign = b[15];
    r.cls  = CLS_FIN;
    r.mant = b[9:0];
    r.expo = -24;
    if (b[14:10] == 5'h1F) begin
      r.cls = (b[9:0] != 0) ? CLS_NAN : CLS_INF;
    end else if (b[14:10] != 0) begin
      r.mant = {1'b1, b[9:0]};
      r.expo = int'(b[14:10]) - 25;
    end
    return r;
  endfunction

  function automatic bit [31:0] round_single(bit sign, longint unsigned m, int e);
    int k, sh, lim, t;
    longint unsigned q, rem, half;
    bit up;
    k = 63;
    while (m[k] == 1'b0) k--;
    sh = k - 23;
    lim = -149 - e;
    if (lim > sh) sh = lim;
    up = 1'b0;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh >= 64) begin
      q = 0;
      up = (sh == 64 && m > 64'h8000_0000_0000_0000);
    end else begin
      rem  = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      q    = m >> sh;
      up   = (rem > half) || (rem == half && q[0]);
    end
    q = q + up;
    t = e + sh;
    if (q >= (64'd1 << 24)) begin
      q = q >> 1;
      t++;
    end
    if (q >= (64'd1 << 23)) begin
      if (t + 150 >= 255) return {sign, 8'hFF, 23'd0};
      return {sign, 8'(t + 150), q[22:0]};
    end
    return {sign, q[30:0]};
  endfunction

  function automatic longint unsigned align_sticky(longint unsigned x, int d);
    longint unsigned lost;
    if (d >= 63) return (x != 0) ? 64'd1 : 64'd0;
    lost = x & ((64'd1 << d) - 1);
    return (x >> d) | ((lost != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic bit [31:0] fma_single(fnum_t a, fnum_t b, fnum_t c);
    bit sp, sgn, pinf;
    longint unsigned mp, mc, m;
    int ep, ec, e;
    sp = a.sign ^ b.sign;
    if (a.cls == CLS_NAN || b.cls == CLS_NAN || c.cls == CLS_NAN) return QNAN;
    pinf = (a.cls == CLS_INF || b.cls == CLS_INF);
    if (pinf && ((a.cls == CLS_FIN && a.mant == 0) || (b.cls == CLS_FIN && b.mant == 0)))
      return QNAN;
    if (pinf) begin
      if (c.cls == CLS_INF && c.sign != sp) return QNAN;
      return {sp, 8'hFF, 23'd0};
    end
    if (c.cls == CLS_INF) return {c.sign, 8'hFF, 23'd0};
    mp = a.mant * b.mant;
    ep = a.expo + b.expo;
    mc = c.mant;
    ec = c.expo;
    if (mp == 0) begin
      if (mc == 0) return (sp == c.sign) ? {sp, 31'd0} : 32'd0;
      return round_single(c.sign, mc, ec);
    end
    if (mc == 0) return round_single(sp, mp, ep);
    while ((mp >> 61) == 0) begin mp = mp << 1; ep--; end
    while ((mc >> 61) == 0) begin mc = mc << 1; ec--; end
    if (ep >= ec) begin
      mc = align_sticky(mc, ep - ec);
      e = ep;
    end else begin
      mp = align_sticky(mp, ec - ep);
      e = ec;
    end
    if (sp == c.sign) begin
      m = mp + mc;
      sgn = sp;
    end else if (mp >= mc) begin
      m = mp - mc;
      sgn = sp;
    end else begin
      m = mc - mp;
      sgn = c.sign;
    end
    if (m == 0) return 32'd0;
    return round_single(sgn, m, e);
  endfunction

  function automatic bit [31:0] add_single(bit [31:0] x, bit [31:0] y);
    fnum_t one;
    one.cls  = CLS_FIN;
    one.sign = 1'b0;
    one.mant = 1;
    one.expo = 0;
    return fma_single(decode_single(x), one, decode_single(y));
  endfunction

  function automatic fnum_t scaled_weight(bit [7:0] wb, bit [15:0] sb);
    fnum_t s, p;
    longint unsigned wmag;
    wmag = wb[7] ? (256 - wb) : wb;
    s = decode_half(sb);
    if (s.cls == CLS_NAN || (s.cls == CLS_INF && wmag == 0)) return decode_single(QNAN);
    p.cls  = s.cls;
    p.sign = wb[7] ^ s.sign;
    p.mant = wmag * s.mant;
    p.expo = s.expo;
    return p;
  endfunction

  int mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    bit [31:0] sum, got, want;
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) lane_acc[i] = 32'd0;
      lane_ptr = 3'd0;
      dot_queue.delete();
      mismatches = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        lane_acc[lane_ptr] = fma_single(scaled_weight(in_mon_i.weight, in_mon_i.block_scale),
                                        decode_single(in_mon_i.vector_value),
                                        decode_single(lane_acc[lane_ptr]));
        lane_ptr = lane_ptr + 3'd1;
        if (in_mon_i.last) begin
          sum = add_single(add_single(add_single(lane_acc[0], lane_acc[4]),
                                      add_single(lane_acc[1], lane_acc[5])),
                           add_single(add_single(lane_acc[2], lane_acc[6]),
                                      add_single(lane_acc[3], lane_acc[7])));
          dot_queue.push_back(sum);
          for (int i = 0; i < LANES; i++) lane_acc[i] = 32'd0;
          lane_ptr = 3'd0;
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = out_mon_i.dot_result;
        if (dot_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected dot result %h", got);
        end else begin
          want = dot_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("dot result mismatch: expected %h, got %h", want, got);
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= dot_queue.size();
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;

  localparam int N_ITEMS    = 1150;
  localparam int IDLE_LIMIT = 3000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   sent;
  int   idle_cycles;

  q8d_in_if  in_ch ();
  q8d_out_if out_ch ();

  quantized_q8_block_dot u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  q8d_dot_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic send_elem(bit [7:0] w, bit [15:0] s, bit [31:0] v, bit l);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.weight       <= w;
    in_ch.block_scale  <= s;
    in_ch.vector_value <= v;
    in_ch.last         <= l;
    in_ch.valid        <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  function automatic bit [31:0] pick_vector();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
      3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      4: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom())};
      5, 6: return $urandom();
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 140)),
                       23'($urandom())};
    endcase
  endfunction

  function automatic bit [15:0] pick_scale();
    case ($urandom_range(0, 15))
      0: return 16'($urandom());
      1: return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom_range(0, 3))};
      2: return {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom())};
      3: return {$urandom_range(0, 1) == 1, 5'h1E, 10'($urandom())};
      default: return {$urandom_range(0, 1) == 1, 5'($urandom_range(5, 20)),
                       10'($urandom())};
    endcase
  endfunction

  initial begin
    int results;
    int gap;
    results = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 6);
      if (results == 40) gap = 400;
      else if (results > 60 && results < 75) gap = 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      results++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int blocks;
    bit [15:0] s;
    sent   = 0;
    blocks = 0;
    rst_ni <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.weight       <= '0;
    in_ch.block_scale  <= '0;
    in_ch.vector_value <= '0;
    in_ch.last         <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_elem(8'd127, 16'h3C00, 32'h3F80_0000, 1'b1);
    send_elem(8'h80, 16'hFBFF, 32'h7F7F_FFFF, 1'b0);
    send_elem(8'h80, 16'hFBFF, 32'h7F7F_FFFF, 1'b1);
    send_elem(8'd0, 16'h7C00, 32'h3F80_0000, 1'b1);
    send_elem(8'd1, 16'h3C00, 32'h7F80_0000, 1'b0);
    send_elem(8'd1, 16'h3C00, 32'hFF80_0000, 1'b1);
    send_elem(8'd1, 16'h3C00, 32'h4000_0000, 1'b0);
    send_elem(8'hFF, 16'h3C00, 32'h4000_0000, 1'b1);
    send_elem(8'hFF, 16'h3C00, 32'h0000_0000, 1'b1);
    send_elem(8'd1, 16'h0001, 32'h0000_0001, 1'b1);
    send_elem(8'd127, 16'h03FF, 32'h0040_0000, 1'b1);
    send_elem(8'd5, 16'h3C00, 32'h7FC1_2345, 1'b1);
    send_elem(8'd5, 16'h7E01, 32'h3F80_0000, 1'b1);
    send_elem(8'h80, 16'h8400, 32'h8000_0000, 1'b1);
    for (int i = 0; i < 9; i++)
      send_elem(8'($urandom()), 16'h3C00, 32'h3F80_0000 + i, i == 8);

    while (sent < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 40);
        1: len = 64;
        default: len = 32;
      endcase
      s = pick_scale();
      for (int i = 0; i < len; i++) begin
        if (i % 32 == 0 && i > 0) s = pick_scale();
        send_elem(8'($urandom()), s, pick_vector(), i == len - 1);
      end
      blocks++;
      if (blocks == 15) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/q8d_pkg.sv
rtl/q8d_if.sv
rtl/q8d_fadd.sv
rtl/quantized_q8_block_dot.sv
tb/sv/q8d_dot_checker.sv
tb/sv/tb_top.sv
